// ===== rtl/fzpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fzpm_pkg
// Shared types and constants for the frame zone profiler with median history.
// ----------------------------------------------------------------------------
package fzpm_pkg;

    localparam int ZONES      = 6;
    localparam int HIST_DEPTH = 64;
    localparam int SLOT_W     = 6;
    localparam int FILL_W     = 7;
    localparam int ROW_W      = 3;
    // zone rows first, then one row of frame times
    localparam int ROWS       = ZONES + 1;
    localparam int ADDR_W     = ROW_W + SLOT_W;
    localparam int MEM_DEPTH  = ROWS * HIST_DEPTH;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [31:0] FREQ_RESET = 32'd1000000000;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  zone_sel;
        logic [63:0] amount_ns;
        logic [63:0] now_tick;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [63:0] frame_time_ns;
        logic        over_budget;
        logic [63:0] zone_median_ns;
        logic [63:0] frame_median_ns;
        logic [63:0] remainder_ns;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       data;
    } t_mem_wr;

endpackage

// ===== rtl/fzpm_hist_mem.sv =====
// ----------------------------------------------------------------------------
// fzpm_hist_mem
// History store: one row per zone plus a row of frame times, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module fzpm_hist_mem
    import fzpm_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [63:0]       o_rdata
);

    logic [63:0] r_mem [MEM_DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fzpm_frame_time.sv =====
// ----------------------------------------------------------------------------
// fzpm_frame_time
// Tick delta to nanoseconds: two-step multiply by 1e9 (mod 2^64), then a
// restoring divide by the tick frequency, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fzpm_frame_time
    import fzpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_delta,
    input  logic [31:0] i_freq,
    output logic        o_done,
    output logic [63:0] o_ns
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL0 = 2'd1;
    localparam logic [1:0] S_MUL1 = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]  r_state;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_delta;
    logic [31:0] r_div;
    logic [63:0] r_prod;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [32:0] trial;
    logic [61:0] mul_lo;
    logic [61:0] mul_hi;
    logic        q_bit;

    assign mul_lo = r_delta[31:0] * NS_PER_SEC;
    assign mul_hi = r_delta[63:32] * NS_PER_SEC;
    assign trial  = {r_rem, r_quo[63]};
    assign q_bit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_done  <= 1'b0;
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0:  r_state <= S_MUL1;
                S_MUL1:  r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == 6'd63) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_delta <= i_delta;
                r_div   <= (i_freq == 32'd0) ? 32'd1 : i_freq;
            end
            S_MUL0: r_prod <= {2'b00, mul_lo};
            S_MUL1: begin
                r_quo <= r_prod + {mul_hi[31:0], 32'd0};
                r_rem <= 32'd0;
                r_cnt <= 6'd0;
            end
            S_DIV: begin
                r_rem <= q_bit ? 32'(trial - {1'b0, r_div}) : trial[31:0];
                r_quo <= {r_quo[62:0], q_bit};
                r_cnt <= r_cnt + 6'd1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_ns   = r_quo;

endmodule

// ===== rtl/frame_zone_profiler_median.sv =====
// ----------------------------------------------------------------------------
// frame_zone_profiler_median
// Per-frame zone time profiler with history rings and median queries.
// ----------------------------------------------------------------------------
// begin and add complete in the idle state; end frame sums the zone accumulators while
//   fzpm_frame_time runs the 1e9 multiply and the bit-serial divide
// query walks the history memory one read a cycle: per row, each candidate tried is
//   compared against all n filled entries until the row's median is found
// one item at a time; the output register lets the next item in while a result waits
// synchronous active-low reset clears control, accumulators and fill count, not history
module frame_zone_profiler_median
    import fzpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ESUM   = 4'd1;
    localparam logic [3:0] S_EWAIT  = 4'd2;
    localparam logic [3:0] S_QCAND  = 4'd3;
    localparam logic [3:0] S_QLOAD  = 4'd4;
    localparam logic [3:0] S_QSCAN  = 4'd5;
    localparam logic [3:0] S_QCHECK = 4'd6;
    localparam logic [3:0] S_QDONE  = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]        r_state;
    logic [31:0]       r_freq;
    logic [63:0]       r_accum [ZONES];
    logic [63:0]       r_start;
    logic              r_overlap;
    logic [SLOT_W-1:0] r_slot;
    logic [FILL_W-1:0] r_fill;
    logic [ROW_W-1:0]  r_row;
    logic [2:0]        r_zone;
    logic [FILL_W-1:0] r_i;
    logic [FILL_W-1:0] r_j;
    logic [FILL_W-1:0] r_below;
    logic [FILL_W-1:0] r_notab;
    logic [63:0]       r_cand;
    logic [63:0]       r_sum;
    logic [63:0]       r_zmed;
    logic [63:0]       r_fmed;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         r_res;

    logic              in_xfer;
    logic              out_free;
    logic [2:0]        acc_idx;
    logic [63:0]       acc_rd;
    t_mem_wr           mem_wr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [63:0]       mem_rdata;
    logic              ft_start;
    logic              ft_done;
    logic [63:0]       ft_ns;
    logic [FILL_W-1:0] k_mid;
    logic              lt;
    logic              le;
    logic              ns_over;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign k_mid       = r_fill >> 1;

    assign acc_idx = (r_state == S_ESUM) ? r_row : i_in_data.zone_sel;
    assign acc_rd  = (acc_idx < ROW_W'(ZONES)) ? r_accum[acc_idx] : 64'd0;

    assign ft_start = in_xfer && (i_in_data.op == OP_END);
    assign ns_over  = ((r_sum + 64'd0) > ft_ns);

    assign lt = (mem_rdata < r_cand);
    assign le = (mem_rdata <= r_cand);

    always_comb begin
        mem_wr.we   = 1'b0;
        mem_wr.addr = {r_row, r_slot};
        mem_wr.data = acc_rd;
        if (r_state == S_ESUM) begin
            mem_wr.we = 1'b1;
        end else if (r_state == S_EWAIT && ft_done) begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = {ROW_W'(ZONES), r_slot};
            mem_wr.data = ft_ns;
        end
        mem_raddr = (r_state == S_QCAND) ? {r_row, r_i[SLOT_W-1:0]}
                                         : {r_row, r_j[SLOT_W-1:0]};
    end

    fzpm_hist_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fzpm_frame_time u_ft (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ft_start),
        .i_delta (i_in_data.now_tick - r_start),
        .i_freq  (r_freq),
        .o_done  (ft_done),
        .o_ns    (ft_ns)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_freq      <= FREQ_RESET;
            r_start     <= 64'd0;
            r_overlap   <= 1'b0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            for (int z = 0; z < ZONES; z++) begin
                r_accum[z] <= 64'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_freq <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_zone <= i_in_data.zone_sel;
                        case (i_in_data.op)
                            OP_BEGIN: begin
                                for (int z = 0; z < ZONES; z++) begin
                                    r_accum[z] <= 64'd0;
                                end
                                r_overlap <= 1'b0;
                                r_start   <= i_in_data.now_tick;
                            end
                            OP_ADD: begin
                                if (acc_idx < ROW_W'(ZONES)) begin
                                    r_accum[acc_idx] <= acc_rd + i_in_data.amount_ns;
                                end
                            end
                            OP_END: begin
                                r_row   <= '0;
                                r_sum   <= 64'd0;
                                r_state <= S_ESUM;
                            end
                            default: begin
                                r_row  <= '0;
                                r_i    <= '0;
                                r_sum  <= 64'd0;
                                r_zmed <= 64'd0;
                                r_fmed <= 64'd0;
                                r_state <= (r_fill == '0) ? S_QDONE : S_QCAND;
                            end
                        endcase
                    end
                end
                S_ESUM: begin
                    r_sum <= r_sum + acc_rd;
                    r_row <= r_row + ROW_W'(1);
                    if (r_row == ROW_W'(ZONES - 1)) begin
                        r_state <= S_EWAIT;
                    end
                end
                S_EWAIT: begin
                    if (ft_done) begin
                        r_overlap <= ns_over;
                        r_slot    <= r_slot + SLOT_W'(1);
                        if (r_fill != FILL_W'(HIST_DEPTH)) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end
                        r_res.kind            <= KIND_REPORT;
                        r_res.frame_time_ns   <= ft_ns;
                        r_res.over_budget     <= ns_over;
                        r_res.zone_median_ns  <= 64'd0;
                        r_res.frame_median_ns <= 64'd0;
                        r_res.remainder_ns    <= 64'd0;
                        r_state <= S_EMIT;
                    end
                end
                S_QCAND: r_state <= S_QLOAD;
                S_QLOAD: begin
                    r_cand  <= mem_rdata;
                    r_below <= '0;
                    r_notab <= '0;
                    r_j     <= '0;
                    r_state <= S_QSCAN;
                end
                S_QSCAN: begin
                    // read data belongs to the previous address, since the memory read port is registered
                    if (r_j != '0) begin
                        r_below <= r_below + FILL_W'(lt);
                        r_notab <= r_notab + FILL_W'(le);
                    end
                    if (r_j == r_fill) begin
                        r_state <= S_QCHECK;
                    end else begin
                        r_j <= r_j + FILL_W'(1);
                    end
                end
                S_QCHECK: begin
                    if (r_below <= k_mid && k_mid < r_notab) begin
                        if (r_row == ROW_W'(ZONES)) begin
                            r_fmed  <= r_cand;
                            r_state <= S_QDONE;
                        end else begin
                            r_sum <= r_sum + r_cand;
                            if (r_zone == r_row) begin
                                r_zmed <= r_cand;
                            end
                            r_row   <= r_row + ROW_W'(1);
                            r_i     <= '0;
                            r_state <= S_QCAND;
                        end
                    end else begin
                        r_i     <= r_i + FILL_W'(1);
                        r_state <= S_QCAND;
                    end
                end
                S_QDONE: begin
                    r_res.kind            <= KIND_QUERY;
                    r_res.frame_time_ns   <= 64'd0;
                    r_res.over_budget     <= 1'b0;
                    r_res.zone_median_ns  <= r_zmed;
                    r_res.frame_median_ns <= r_fmed;
                    r_res.remainder_ns    <= (r_fmed > r_sum) ? (r_fmed - r_sum) : 64'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST_DEPTH))
        else $error("fill count beyond history depth");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.we |-> (r_state == S_ESUM || r_state == S_EWAIT))
        else $error("history written outside end of frame");

    a_end_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWAIT && ft_done) |=> (r_slot == $past(r_slot) + SLOT_W'(1)))
        else $error("write slot did not advance at end of frame");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QCHECK) |-> (r_row <= ROW_W'(ZONES) && r_i < r_fill))
        else $error("median search out of range");

endmodule
